// ===== hdl/psyd_pkg.sv =====
// ----------------------------------------------------------------------------
// psyd_pkg - shared constants for the PID speed and yaw drive
// Field widths, register indexes, reset values, gear codes and limits.
// ----------------------------------------------------------------------------
package psyd_pkg;

    // Field widths
    localparam int DataW   = 16;   // Q8.8 payload and gains
    localparam int MarginW = 15;   // brake margin and dead band
    localparam int TimeW   = 32;   // timestamp ticks
    localparam int GearW   = 3;
    localparam int CfgIdxW = 4;

    // Datapath widths
    localparam int IntW    = 32;   // error integral, Q16.16
    localparam int MulAW   = 33;   // signed operand A of the shared multiplier
    localparam int MulBW   = 17;   // signed operand B of the shared multiplier
    localparam int ProdW   = MulAW + MulBW;
    localparam int TotalW  = 58;   // PID sum before the final shift
    localparam int AccW    = TotalW - 16;
    localparam int BrkAccW = 26;   // drive clipped ahead of the brake scaling
    localparam int DivSteps = 32;
    localparam int DivCntW  = $clog2(DivSteps);

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx RegTargetSpeed = 4'd0;
    localparam t_cfg_idx RegTargetYaw   = 4'd1;
    localparam t_cfg_idx RegGainP       = 4'd2;
    localparam t_cfg_idx RegGainI       = 4'd3;
    localparam t_cfg_idx RegGainD       = 4'd4;
    localparam t_cfg_idx RegBrakeMargin = 4'd5;
    localparam t_cfg_idx RegDeadBand    = 4'd6;
    localparam t_cfg_idx RegBrakeScale  = 4'd7;

    // Reset values of the nonzero registers (1.0 in Q8.8)
    localparam logic [DataW-1:0] GainPReset      = 16'd256;
    localparam logic [DataW-1:0] BrakeScaleReset = 16'd256;

    // Output limits
    localparam logic signed [DataW-1:0] DriveMax = 16'sd256;
    localparam logic signed [DataW-1:0] SatMin   = 16'sh8000;
    localparam logic signed [DataW-1:0] SatMax   = 16'sh7FFF;

    // Drive clip ahead of the brake scaling: +/- 2^24
    localparam logic signed [BrkAccW-1:0] BrkAccLim = 26'sh100_0000;

    // Gear codes
    localparam logic signed [GearW-1:0] GearFwd  = 3'sd2;
    localparam logic signed [GearW-1:0] GearRev  = 3'sb111;
    localparam logic signed [GearW-1:0] GearNone = 3'sd0;

endpackage

// ===== hdl/pid_speed_and_yaw_drive.sv =====
// ----------------------------------------------------------------------------
// pid_speed_and_yaw_drive - PID speed loop with throttle/brake select and yaw
// Forms the speed error, its integral and derivative, sums the PID terms on
// one shared multiplier and picks forward, braking, reverse or coasting drive.
// ----------------------------------------------------------------------------
//
//  channel   handshake                    payload
//  -------   ---------------------------  ---------------------------------------
//  sample    i_valid / o_ready            i_speed, i_yaw_rate, i_sample_time
//  result    o_valid / i_ready            o_throttle, o_brake, o_steering,
//                                         o_manual_sel, o_gear
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  After a target_speed write or reset an item has no integral or derivative
//  terms; otherwise it runs the 32-step restoring divider for the derivative
//  and makes five passes through the shared 33x17 multiplier. o_ready is
//  high only while the sequencer is idle. Reset is synchronous, active low;
//  it restores the register defaults and empties the error history. The
//  result sits in an output register, so a new item is taken while a result
//  waits; the sequencer holds in its last step only when the output register
//  is still full at that point. The config port is always ready; it must be
//  written by the user only while idle, and the block does not enforce this.

module pid_speed_and_yaw_drive (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [psyd_pkg::DataW-1:0]      i_speed,
    input  logic signed [psyd_pkg::DataW-1:0]      i_yaw_rate,
    input  logic        [psyd_pkg::TimeW-1:0]      i_sample_time,

    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [psyd_pkg::DataW-1:0]      o_throttle,
    output logic signed [psyd_pkg::DataW-1:0]      o_brake,
    output logic signed [psyd_pkg::DataW-1:0]      o_steering,
    output logic                                   o_manual_sel,
    output logic signed [psyd_pkg::GearW-1:0]      o_gear,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [psyd_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic        [psyd_pkg::DataW-1:0]      i_cfg_data
);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;  // wait for an item
    localparam logic [3:0] ST_INC  = 4'd1;  // multiply error by interval
    localparam logic [3:0] ST_INT  = 4'd2;  // update integral, multiply P term
    localparam logic [3:0] ST_PT   = 4'd3;  // load P term, multiply I term
    localparam logic [3:0] ST_IT   = 4'd4;  // add I term, seed divider
    localparam logic [3:0] ST_DIV  = 4'd5;  // one quotient bit per cycle
    localparam logic [3:0] ST_DM   = 4'd6;  // multiply D term
    localparam logic [3:0] ST_DA   = 4'd7;  // add D term
    localparam logic [3:0] ST_BRK  = 4'd8;  // multiply drive by brake scale
    localparam logic [3:0] ST_FIN  = 4'd9;  // select drive, load output

    localparam logic signed [psyd_pkg::AccW-1:0] AccHi =
        psyd_pkg::AccW'(psyd_pkg::DriveMax);
    localparam logic signed [psyd_pkg::AccW-1:0] AccLo =
        psyd_pkg::AccW'(psyd_pkg::SatMin);
    localparam logic signed [psyd_pkg::AccW-1:0] AccBrkHi =
        psyd_pkg::AccW'(psyd_pkg::BrkAccLim);
    localparam logic signed [psyd_pkg::AccW-1:0] AccBrkLo =
        -psyd_pkg::AccW'(psyd_pkg::BrkAccLim);

    // Configuration registers
    logic signed [psyd_pkg::DataW-1:0]   r_target_speed;
    logic signed [psyd_pkg::DataW-1:0]   r_target_yaw;
    logic        [psyd_pkg::DataW-1:0]   r_gain_p;
    logic        [psyd_pkg::DataW-1:0]   r_gain_i;
    logic        [psyd_pkg::DataW-1:0]   r_gain_d;
    logic        [psyd_pkg::MarginW-1:0] r_brake_margin;
    logic        [psyd_pkg::MarginW-1:0] r_dead_band;
    logic        [psyd_pkg::DataW-1:0]   r_brake_scale;

    // Loop history
    logic [psyd_pkg::IntW-1:0]  r_integral;
    logic [psyd_pkg::DataW-1:0] r_prev_err;
    logic [psyd_pkg::TimeW-1:0] r_prev_time;
    logic                       r_hist_empty;

    // Sequencer and output control
    logic [3:0]                      r_state;
    logic [psyd_pkg::DivCntW-1:0]    r_cnt;
    logic                            r_out_valid;

    // Item datapath
    logic signed [psyd_pkg::DataW-1:0]  r_speed;
    logic signed [psyd_pkg::DataW-1:0]  r_yaw;
    logic        [psyd_pkg::DataW-1:0]  r_err;
    logic        [psyd_pkg::TimeW-1:0]  r_dt;
    logic signed [psyd_pkg::ProdW-1:0]  r_prod;
    logic        [psyd_pkg::TotalW-1:0] r_total;
    logic        [psyd_pkg::TimeW-1:0]  r_rem;
    logic        [psyd_pkg::TimeW-1:0]  r_quo;
    logic                               r_neg;

    // Output payload registers
    logic signed [psyd_pkg::DataW-1:0]  r_throttle;
    logic signed [psyd_pkg::DataW-1:0]  r_brake;
    logic signed [psyd_pkg::DataW-1:0]  r_steering;
    logic                               r_manual;
    logic signed [psyd_pkg::GearW-1:0]  r_gear;

    logic in_take;
    logic out_load;

    assign in_take     = i_valid && (r_state == ST_IDLE);
    assign out_load    = (r_state == ST_FIN) && (!r_out_valid || i_ready);
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Speed error at the input: |target - speed| always fits 16 bits
    // ------------------------------------------------------------------
    logic signed [psyd_pkg::DataW:0] in_diff;
    logic        [psyd_pkg::DataW:0] in_diff_abs;

    always_comb begin
        in_diff     = {r_target_speed[psyd_pkg::DataW-1], r_target_speed}
                    - {i_speed[psyd_pkg::DataW-1], i_speed};
        in_diff_abs = in_diff[psyd_pkg::DataW] ? -in_diff : in_diff;
    end

    // ------------------------------------------------------------------
    // Integral update: saturate at all ones
    // ------------------------------------------------------------------
    logic [psyd_pkg::ProdW-9:0] inc;     // (err * dt) >> 8
    logic [psyd_pkg::ProdW-8:0] int_sum;
    logic [psyd_pkg::IntW-1:0]  n_integral;

    always_comb begin
        inc     = r_prod[psyd_pkg::ProdW-1:8];
        int_sum = {1'b0, inc} + (psyd_pkg::ProdW-7)'(r_integral);
        if (r_hist_empty) begin
            n_integral = (|inc[psyd_pkg::ProdW-9:psyd_pkg::IntW]) ? '1
                                                                  : inc[psyd_pkg::IntW-1:0];
        end else begin
            n_integral = (|int_sum[psyd_pkg::ProdW-8:psyd_pkg::IntW]) ? '1
                                                                      : int_sum[psyd_pkg::IntW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Derivative numerator and one restoring division step
    // ------------------------------------------------------------------
    logic signed [psyd_pkg::DataW:0]   d_diff;
    logic        [psyd_pkg::DataW:0]   d_mag;
    logic        [psyd_pkg::TimeW:0]   rem_sh;
    logic        [psyd_pkg::TimeW:0]   rem_sub;
    logic                              rem_ge;
    logic signed [psyd_pkg::MulAW-1:0] deriv;

    always_comb begin
        d_diff  = {1'b0, r_err} - {1'b0, r_prev_err};
        d_mag   = d_diff[psyd_pkg::DataW] ? -d_diff : d_diff;
        rem_sh  = {r_rem, r_quo[psyd_pkg::TimeW-1]};
        rem_sub = rem_sh - {1'b0, r_dt};
        rem_ge  = (rem_sh >= {1'b0, r_dt});
        // Zero interval gives no derivative
        if (r_dt == '0) begin
            deriv = '0;
        end else if (r_neg) begin
            deriv = -$signed({1'b0, r_quo});
        end else begin
            deriv = $signed({1'b0, r_quo});
        end
    end

    // ------------------------------------------------------------------
    // Drive: PID sum >> 16, and a clipped copy for the brake product
    // ------------------------------------------------------------------
    logic signed [psyd_pkg::AccW-1:0]    acc;
    logic signed [psyd_pkg::BrkAccW-1:0] acc_brk;

    always_comb begin
        acc = $signed(r_total[psyd_pkg::TotalW-1:16]);
        // Beyond 2^24 the scaled brake saturates anyway (or is 0 for scale 0)
        if (acc > AccBrkHi) begin
            acc_brk = psyd_pkg::BrkAccLim;
        end else if (acc < AccBrkLo) begin
            acc_brk = -psyd_pkg::BrkAccLim;
        end else begin
            acc_brk = acc[psyd_pkg::BrkAccW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    logic signed [psyd_pkg::MulAW-1:0] mul_a;
    logic signed [psyd_pkg::MulBW-1:0] mul_b;
    logic                              mul_en;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (r_state)
            ST_INC: begin
                mul_a = $signed({1'b0, r_dt});
                mul_b = $signed({1'b0, r_err});
            end
            ST_INT: begin
                mul_a = $signed(psyd_pkg::MulAW'(r_err));
                mul_b = $signed({1'b0, r_gain_p});
            end
            ST_PT: begin
                mul_a = $signed({1'b0, r_integral});
                mul_b = $signed({1'b0, r_gain_i});
            end
            ST_DM: begin
                mul_a = deriv;
                mul_b = $signed({1'b0, r_gain_d});
            end
            ST_BRK: begin
                mul_a = psyd_pkg::MulAW'(acc_brk);
                mul_b = $signed({1'b0, r_brake_scale});
            end
            default: begin
                // Hold the product: the final step reads the brake product
                mul_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Drive selection and steering
    // ------------------------------------------------------------------
    logic signed [psyd_pkg::DataW+1:0] sp_x;
    logic signed [psyd_pkg::DataW+1:0] tg_x;
    logic signed [psyd_pkg::DataW+1:0] bm_x;
    logic signed [psyd_pkg::DataW+1:0] db_x;
    logic signed [psyd_pkg::DataW+1:0] ty_x;
    logic signed [psyd_pkg::DataW+1:0] yw_x;
    logic signed [psyd_pkg::DataW+1:0] yaw_err;
    logic signed [psyd_pkg::AccW-1:0]  brk_acc;
    logic signed [psyd_pkg::DataW-1:0] thr_sat;
    logic signed [psyd_pkg::DataW-1:0] brk_sat;
    logic signed [psyd_pkg::DataW-1:0] n_throttle;
    logic signed [psyd_pkg::DataW-1:0] n_brake;
    logic signed [psyd_pkg::DataW-1:0] n_steering;
    logic                              n_manual;
    logic signed [psyd_pkg::GearW-1:0] n_gear;

    always_comb begin
        sp_x    = (psyd_pkg::DataW+2)'(r_speed);
        tg_x    = (psyd_pkg::DataW+2)'(r_target_speed);
        bm_x    = $signed((psyd_pkg::DataW+2)'(r_brake_margin));
        db_x    = $signed((psyd_pkg::DataW+2)'(r_dead_band));
        ty_x    = (psyd_pkg::DataW+2)'(r_target_yaw);
        yw_x    = (psyd_pkg::DataW+2)'(r_yaw);
        yaw_err = ty_x - yw_x;
        brk_acc = $signed(r_prod[psyd_pkg::ProdW-1:8]);

        if (acc > AccHi) begin
            thr_sat = psyd_pkg::DriveMax;
        end else if (acc < AccLo) begin
            thr_sat = psyd_pkg::SatMin;
        end else begin
            thr_sat = acc[psyd_pkg::DataW-1:0];
        end

        if (brk_acc > AccHi) begin
            brk_sat = psyd_pkg::DriveMax;
        end else if (brk_acc < AccLo) begin
            brk_sat = psyd_pkg::SatMin;
        end else begin
            brk_sat = brk_acc[psyd_pkg::DataW-1:0];
        end

        n_throttle = '0;
        n_brake    = '0;
        n_manual   = 1'b0;
        n_gear     = psyd_pkg::GearNone;
        priority if (sp_x < tg_x) begin
            n_throttle = thr_sat;
            n_manual   = 1'b1;
            n_gear     = psyd_pkg::GearFwd;
        end else if ((sp_x > tg_x + bm_x) && (sp_x > db_x)) begin
            n_brake = brk_sat;
        end else if ((sp_x > tg_x) && (tg_x < 0)) begin
            n_throttle = thr_sat;
            n_manual   = 1'b1;
            n_gear     = psyd_pkg::GearRev;
        end else begin
            // Coast: all drive outputs stay zero
            n_throttle = '0;
        end

        // Steer only outside the dead band around the target yaw rate
        if ((yw_x < ty_x - db_x) || (yw_x > ty_x + db_x)) begin
            if (yaw_err > (psyd_pkg::DataW+2)'(psyd_pkg::SatMax)) begin
                n_steering = psyd_pkg::SatMax;
            end else if (yaw_err < (psyd_pkg::DataW+2)'(psyd_pkg::SatMin)) begin
                n_steering = psyd_pkg::SatMin;
            end else begin
                n_steering = yaw_err[psyd_pkg::DataW-1:0];
            end
        end else begin
            n_steering = '0;
        end
    end

    // ------------------------------------------------------------------
    // Control state, configuration and loop history
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_target_speed <= '0;
            r_target_yaw   <= '0;
            r_gain_p       <= psyd_pkg::GainPReset;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_brake_margin <= '0;
            r_dead_band    <= '0;
            r_brake_scale  <= psyd_pkg::BrakeScaleReset;
            r_integral     <= '0;
            r_prev_err     <= '0;
            r_prev_time    <= '0;
            r_hist_empty   <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    psyd_pkg::RegTargetSpeed: begin
                        r_target_speed <= $signed(i_cfg_data);
                        r_hist_empty   <= 1'b1;   // restart the integral history
                    end
                    psyd_pkg::RegTargetYaw:   r_target_yaw   <= $signed(i_cfg_data);
                    psyd_pkg::RegGainP:       r_gain_p       <= i_cfg_data;
                    psyd_pkg::RegGainI:       r_gain_i       <= i_cfg_data;
                    psyd_pkg::RegGainD:       r_gain_d       <= i_cfg_data;
                    psyd_pkg::RegBrakeMargin: r_brake_margin <= i_cfg_data[psyd_pkg::MarginW-1:0];
                    psyd_pkg::RegDeadBand:    r_dead_band    <= i_cfg_data[psyd_pkg::MarginW-1:0];
                    psyd_pkg::RegBrakeScale:  r_brake_scale  <= i_cfg_data;
                    default: begin
                        // Drop writes beyond the register list
                    end
                endcase
            end

            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_prev_time <= i_sample_time;
                        r_state     <= ST_INC;
                    end
                end
                ST_INC: r_state <= ST_INT;
                ST_INT: begin
                    r_integral <= n_integral;
                    r_state    <= ST_PT;
                end
                ST_PT:  r_state <= r_hist_empty ? ST_BRK : ST_IT;
                ST_IT:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_cnt == psyd_pkg::DivCntW'(psyd_pkg::DivSteps - 1)) begin
                        r_state <= ST_DM;
                    end
                end
                ST_DM:  r_state <= ST_DA;
                ST_DA:  r_state <= ST_BRK;
                ST_BRK: r_state <= ST_FIN;
                ST_FIN: begin
                    // Hold until the output register is free
                    if (out_load) begin
                        r_out_valid  <= 1'b1;
                        r_prev_err   <= r_err;
                        r_hist_empty <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end

        if (in_take) begin
            r_speed <= i_speed;
            r_yaw   <= i_yaw_rate;
            r_err   <= in_diff_abs[psyd_pkg::DataW-1:0];
            r_dt    <= i_sample_time - r_prev_time;   // wraps modulo 2^32
        end

        unique case (r_state)
            ST_PT: begin
                // P term scaled by 2^8; alone it gives gain_p * err >> 8
                r_total <= {r_prod, 8'b0};
            end
            ST_IT: begin
                r_total <= r_total
                         + {{(psyd_pkg::TotalW - psyd_pkg::ProdW){r_prod[psyd_pkg::ProdW-1]}},
                            r_prod};
                r_rem   <= '0;
                r_quo   <= {d_mag[psyd_pkg::DataW-1:0], 16'b0};
                r_neg   <= d_diff[psyd_pkg::DataW];
                r_cnt   <= '0;
            end
            ST_DIV: begin
                r_rem <= rem_ge ? rem_sub[psyd_pkg::TimeW-1:0] : rem_sh[psyd_pkg::TimeW-1:0];
                r_quo <= {r_quo[psyd_pkg::TimeW-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_DA: begin
                r_total <= r_total + {r_prod, 8'b0};
            end
            default: begin
                // Hold the working registers
            end
        endcase

        if (out_load) begin
            r_throttle <= n_throttle;
            r_brake    <= n_brake;
            r_steering <= n_steering;
            r_manual   <= n_manual;
            r_gear     <= n_gear;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_throttle   = r_throttle;
    assign o_brake      = r_brake;
    assign o_steering   = r_steering;
    assign o_manual_sel = r_manual;
    assign o_gear       = r_gear;

endmodule

// ===== test/tb_pid_speed_and_yaw_drive.sv =====
// ----------------------------------------------------------------------------
// tb_pid_speed_and_yaw_drive - self-checking bench for the PID speed/yaw drive
// Drives samples and register writes with random idling on both handshakes,
// predicts every drive result in-bench and compares it field by field.
// ----------------------------------------------------------------------------
module tb_pid_speed_and_yaw_drive;

    localparam int HoldCycles = 400;      // long result-side stall
    localparam int PhaseItems = 50;
    localparam int PhaseCount = 11;

    typedef logic signed [63:0] t_wide;

    // One drive result as it leaves the block
    typedef struct {
        logic signed [psyd_pkg::DataW-1:0] throttle;
        logic signed [psyd_pkg::DataW-1:0] brake;
        logic signed [psyd_pkg::DataW-1:0] steering;
        logic                              manual;
        logic signed [psyd_pkg::GearW-1:0] gear;
    } t_drive_out;

    // ------------------------------------------------------------------------
    // Drive tracker: mirrors the registers and the error history, turns every
    // accepted sample into its expected drive, and checks results in order.
    // ------------------------------------------------------------------------
    class t_drive_tracker;
        logic signed [psyd_pkg::DataW-1:0] tgt_speed, tgt_yaw;
        logic [psyd_pkg::DataW-1:0]        kp, ki, kd, brk_scale;
        logic [psyd_pkg::MarginW-1:0]      brk_margin, band;
        logic [psyd_pkg::IntW-1:0]         err_sum;
        logic [psyd_pkg::DataW-1:0]        last_err;
        logic [psyd_pkg::TimeW-1:0]        last_time;
        bit                                fresh;
        t_drive_out                        expected_drives[$];
        int unsigned                       mismatches;

        function new();
            tgt_speed  = '0;
            tgt_yaw    = '0;
            kp         = psyd_pkg::GainPReset;
            ki         = '0;
            kd         = '0;
            brk_margin = '0;
            band       = '0;
            brk_scale  = psyd_pkg::BrakeScaleReset;
            err_sum    = '0;
            last_err   = '0;
            last_time  = '0;
            fresh      = 1'b1;
            mismatches = 0;
        endfunction

        function void set_reg(psyd_pkg::t_cfg_idx idx, logic [psyd_pkg::DataW-1:0] data);
            case (idx)
                psyd_pkg::RegTargetSpeed: begin
                    tgt_speed = data;
                    fresh     = 1'b1;   // a new target restarts the history
                end
                psyd_pkg::RegTargetYaw:   tgt_yaw    = data;
                psyd_pkg::RegGainP:       kp         = data;
                psyd_pkg::RegGainI:       ki         = data;
                psyd_pkg::RegGainD:       kd         = data;
                psyd_pkg::RegBrakeMargin: brk_margin = data[psyd_pkg::MarginW-1:0];
                psyd_pkg::RegDeadBand:    band       = data[psyd_pkg::MarginW-1:0];
                psyd_pkg::RegBrakeScale:  brk_scale  = data;
                default: ;              // unknown index: drop the write
            endcase
        endfunction

        function longint limit(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        function void note_sample(logic signed [psyd_pkg::DataW-1:0] spd,
                                  logic signed [psyd_pkg::DataW-1:0] yaw,
                                  logic [psyd_pkg::TimeW-1:0] stamp);
            longint                      s, tg, ty, y, acc, deriv, total, bm, db;
            longint unsigned             inc, sum;
            logic [psyd_pkg::DataW-1:0]  err;
            logic [psyd_pkg::TimeW-1:0]  dt;
            t_drive_out                  want;
            s   = spd;
            y   = yaw;
            tg  = tgt_speed;
            ty  = tgt_yaw;
            bm  = longint'(brk_margin);
            db  = longint'(band);
            err = (tg >= s) ? 16'(tg - s) : 16'(s - tg);
            dt  = stamp - last_time;    // wraps modulo 2^32
            inc = (64'(err) * 64'(dt)) >> 8;
            if (fresh) begin
                // first sample of a history: proportional term only
                acc     = (longint'(kp) * longint'(err)) >>> 8;
                err_sum = (inc > 64'hFFFF_FFFF) ? '1 : 32'(inc);
                fresh   = 1'b0;
            end else begin
                sum     = 64'(err_sum) + inc;
                err_sum = (sum > 64'hFFFF_FFFF) ? '1 : 32'(sum);
                deriv   = 0;
                if (dt != 0)
                    deriv = (longint'(err) - longint'(last_err)) * 64'sd65536
                            / longint'(dt);
                total = longint'(kp) * longint'(err) * 64'sd256
                      + longint'(ki) * longint'(err_sum)
                      + longint'(kd) * deriv * 64'sd256;
                acc   = total >>> 16;
            end
            last_err  = err;
            last_time = stamp;

            want.throttle = '0;
            want.brake    = '0;
            want.steering = '0;
            want.manual   = 1'b0;
            want.gear     = psyd_pkg::GearNone;
            if (s < tg) begin
                want.throttle = 16'(limit(acc, -32768, 256));
                want.manual   = 1'b1;
                want.gear     = psyd_pkg::GearFwd;
            end else if (s > tg + bm && s > db) begin
                want.brake = 16'(limit((acc * longint'(brk_scale)) >>> 8, -32768, 256));
            end else if (s > tg && tg < 0) begin
                want.throttle = 16'(limit(acc, -32768, 256));
                want.manual   = 1'b1;
                want.gear     = psyd_pkg::GearRev;
            end
            if (y < ty - db || y > ty + db)
                want.steering = 16'(limit(ty - y, -32768, 32767));
            expected_drives.push_back(want);
        endfunction

        task report(string what, t_wide got, t_wide want);
            mismatches++;
            $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want,
                     $realtime);
        endtask

        task compare_field(string what, t_wide got, t_wide want);
            if (got !== want)
                report(what, got, want);
        endtask

        task check_drive(t_drive_out got);
            t_drive_out want;
            if (expected_drives.size() == 0) begin
                report("result with nothing pending", got.throttle, 0);
                return;
            end
            want = expected_drives.pop_front();
            compare_field("throttle", got.throttle, want.throttle);
            compare_field("brake", got.brake, want.brake);
            compare_field("steering", got.steering, want.steering);
            compare_field("manual_sel", t_wide'({1'b0, got.manual}),
                          t_wide'({1'b0, want.manual}));
            compare_field("gear", got.gear, want.gear);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, ports and the block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    logic                                 i_rst_n;
    logic                                 i_valid, o_ready;
    logic signed [psyd_pkg::DataW-1:0]    i_speed, i_yaw_rate;
    logic        [psyd_pkg::TimeW-1:0]    i_sample_time;
    logic                                 o_valid, i_ready;
    logic signed [psyd_pkg::DataW-1:0]    o_throttle, o_brake, o_steering;
    logic                                 o_manual_sel;
    logic signed [psyd_pkg::GearW-1:0]    o_gear;
    logic                                 i_cfg_valid, o_cfg_ready;
    logic        [psyd_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic        [psyd_pkg::DataW-1:0]    i_cfg_data;

    pid_speed_and_yaw_drive u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_speed       (i_speed),
        .i_yaw_rate    (i_yaw_rate),
        .i_sample_time (i_sample_time),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_throttle    (o_throttle),
        .o_brake       (o_brake),
        .o_steering    (o_steering),
        .o_manual_sel  (o_manual_sel),
        .o_gear        (o_gear),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    t_drive_tracker tracker = new();

    int unsigned                hold_requests = 0;  // bumped by the sender side, served by the sink
    int unsigned                src_calm = 0;       // samples left in a sender stretch without gaps
    logic [psyd_pkg::TimeW-1:0] last_stamp = '0;

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(15, 50);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 120);
    endfunction

    // ------------------------------------------------------------------------
    // Result sink: sample at the edge, check, then decide ready for the next
    // cycle. A hold request parks ready low for HoldCycles, counted here.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned idle_left, hold_left, calm, holds_served;
        logic        next_ready, taken;
        t_drive_out  got;
        idle_left    = 0;
        hold_left    = 0;
        calm         = 0;
        holds_served = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            taken = i_ready && o_valid;
            if (taken) begin
                got.throttle = o_throttle;
                got.brake    = o_brake;
                got.steering = o_steering;
                got.manual   = o_manual_sel;
                got.gear     = o_gear;
                tracker.check_drive(got);
            end
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HoldCycles;
            end
            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (idle_left != 0) begin
                idle_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
                // after each taken result, maybe back off for a while
                if (taken) begin
                    idle_left = next_gap(calm);
                    if (idle_left != 0) begin
                        idle_left--;
                        next_ready = 1'b0;
                    end
                end
            end
            i_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each returns at the edge where its item was taken, so a
    // following item with no gap keeps valid high without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [psyd_pkg::DataW-1:0] spd,
                               input logic signed [psyd_pkg::DataW-1:0] yaw,
                               input logic [psyd_pkg::TimeW-1:0] stamp,
                               input int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_speed       <= spd;
        i_yaw_rate    <= yaw;
        i_sample_time <= stamp;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_sample(spd, yaw, stamp);
        last_stamp = stamp;
    endtask

    // Random sample: mostly near the targets with a steadily advancing clock,
    // the rest full-range values, extremes, repeated and wild timestamps.
    task automatic send_random(input int unsigned gap);
        logic signed [psyd_pkg::DataW-1:0] spd, yaw;
        logic [psyd_pkg::TimeW-1:0]        stamp;
        int unsigned                       pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            spd = tracker.tgt_speed + 16'($urandom_range(0, 1023)) - 16'd512;
        else if (pick < 8)
            spd = 16'($urandom);
        else if (pick == 8)
            spd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
            spd = tracker.tgt_speed;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            yaw = tracker.tgt_yaw + 16'($urandom_range(0, 1023)) - 16'd512;
        else if (pick == 2)
            yaw = 16'($urandom);
        else
            yaw = tracker.tgt_yaw + 16'(tracker.band) + 16'($urandom_range(0, 2)) - 16'd1;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            stamp = last_stamp + 32'($urandom_range(1, 3000));
        else if (pick == 7)
            stamp = last_stamp;                 // zero interval
        else if (pick == 8)
            stamp = $urandom;
        else
            stamp = last_stamp - 32'($urandom_range(1, 64));  // long wrap-around interval
        send_sample(spd, yaw, stamp, gap);
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.expected_drives.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input psyd_pkg::t_cfg_idx idx,
                             input logic [psyd_pkg::DataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // style 0: low extremes, 1: high extremes, 2: typical on a random subset,
    // 3: typical on every register
    task automatic random_config(input int unsigned style);
        logic [psyd_pkg::DataW-1:0] val;
        for (int r = 0; r < 16; r++) begin
            if (style == 2 && $urandom_range(0, 2) == 0) continue;
            case (psyd_pkg::t_cfg_idx'(r))
                psyd_pkg::RegTargetSpeed, psyd_pkg::RegTargetYaw: begin
                    if (style == 0)      val = 16'h8000;
                    else if (style == 1) val = 16'h7FFF;
                    else if ($urandom_range(0, 3) == 0) val = 16'($urandom);
                    else val = 16'($urandom_range(0, 4096)) - 16'd2048;
                end
                psyd_pkg::RegGainP, psyd_pkg::RegGainI, psyd_pkg::RegGainD,
                psyd_pkg::RegBrakeScale: begin
                    if (style == 0)      val = 16'h0000;
                    else if (style == 1) val = 16'hFFFF;
                    else if ($urandom_range(0, 7) == 0) val = 16'($urandom);
                    else val = 16'($urandom_range(0, 768));
                end
                psyd_pkg::RegBrakeMargin, psyd_pkg::RegDeadBand: begin
                    // the top data bit is outside these registers
                    if (style == 0)      val = 16'h8000;
                    else if (style == 1) val = 16'hFFFF;
                    else val = 16'($urandom_range(0, 640)) | 16'($urandom_range(0, 1) << 15);
                end
                default: begin
                    if ($urandom_range(0, 3) != 0) continue;
                    val = 16'($urandom);
                end
            endcase
            cfg_write(psyd_pkg::t_cfg_idx'(r), val);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_speed       = '0;
        i_yaw_rate    = '0;
        i_sample_time = '0;
        i_ready       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: first sample after reset, braking on proportional only
        send_sample(16'sd256, 16'sd0, 32'd0, 0);
        drain();

        // Moderate settings, every register, plus two unknown indexes
        cfg_write(psyd_pkg::RegTargetSpeed, 16'd512);
        cfg_write(psyd_pkg::RegTargetYaw,   16'd100);
        cfg_write(psyd_pkg::RegGainP,       16'd256);
        cfg_write(psyd_pkg::RegGainI,       16'd128);
        cfg_write(psyd_pkg::RegGainD,       16'd64);
        cfg_write(psyd_pkg::RegBrakeMargin, 16'd64);
        cfg_write(psyd_pkg::RegDeadBand,    16'd32);
        cfg_write(psyd_pkg::RegBrakeScale,  16'd512);
        cfg_write(psyd_pkg::t_cfg_idx'(8),  16'hFFFF);
        cfg_write(psyd_pkg::t_cfg_idx'(15), 16'h1234);
        send_sample(16'sd0, 16'sd0, 32'd1000, 0);                 // fresh history
        send_sample(16'sd0, 16'sd0, 32'd1000, 2);                 // zero interval
        send_sample(16'sd256, 16'sd200, 32'd5000, 0);             // error shrinking
        send_sample(16'sh7FFF, 16'sh7FFF, 32'd9000, 5);           // braking
        send_sample(16'sh8000, 16'sh8000, 32'hFFFF_FFF0, 0);      // huge interval
        send_sample(16'sh8000, 16'sh8000, 32'h0000_0010, 0);      // timestamp wraps
        send_sample(16'sd540, 16'sd100, 32'h0000_0100, 1);        // coast, yaw in band
        send_sample(16'sd512, 16'sd133, 32'h0000_0200, 0);        // coast, yaw just out
        drain();

        // Negative target with wide margins: reverse gear
        cfg_write(psyd_pkg::RegTargetSpeed, -16'sd1024);
        cfg_write(psyd_pkg::RegBrakeMargin, 16'h7FFF);
        cfg_write(psyd_pkg::RegDeadBand,    16'h7FFF);
        send_sample(-16'sd500, 16'sh8000, 32'h300, 0);
        send_sample(16'sh7FFF, 16'sd0, 32'h400, 0);
        send_sample(-16'sd1024, 16'sd0, 32'h500, 3);
        drain();

        // Extreme gains: the integral saturates, steering clips low
        cfg_write(psyd_pkg::RegTargetSpeed, 16'h7FFF);
        cfg_write(psyd_pkg::RegTargetYaw,   16'h8000);
        cfg_write(psyd_pkg::RegGainP,       16'hFFFF);
        cfg_write(psyd_pkg::RegGainI,       16'hFFFF);
        cfg_write(psyd_pkg::RegGainD,       16'hFFFF);
        cfg_write(psyd_pkg::RegBrakeMargin, 16'h0000);
        cfg_write(psyd_pkg::RegDeadBand,    16'h8000);
        cfg_write(psyd_pkg::RegBrakeScale,  16'h0000);
        send_sample(16'sh8000, 16'sh7FFF, 32'h0, 0);
        send_sample(16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF, 0);
        send_sample(16'sh8000, 16'sd0, 32'hFFFF_FFFF, 0);
        send_sample(16'sh7FFF, 16'sh7FFF, 32'h1_0000, 0);
        drain();

        // Lowest target: braking at full scale, reverse, negative drive
        cfg_write(psyd_pkg::RegTargetSpeed, 16'h8000);
        cfg_write(psyd_pkg::RegTargetYaw,   16'h7FFF);
        cfg_write(psyd_pkg::RegBrakeScale,  16'hFFFF);
        send_sample(16'sd100, 16'sh8000, 32'd10, 0);
        send_sample(16'sh8000, 16'sh7FFF, 32'd20, 0);
        send_sample(-16'sd100, 16'sd0, 32'd30, 0);
        send_sample(-16'sd32767, 16'sd0, 32'd40, 0);              // error drops: drive < 0
        send_sample(16'sd50, 16'sd0, 32'd41, 0);
        drain();

        // Random phases: reconfigure while idle, then a run of samples
        for (int p = 0; p < PhaseCount; p++) begin
            random_config(p == 0 ? 3 : (p == 1 ? 0 : (p == 2 ? 1 : 2)));
            if (p == 4) begin
                // stall the sink for a long time and keep offering back to back
                hold_requests <= hold_requests + 1;
                repeat (12) send_random(0);
            end
            repeat (PhaseItems) send_random(next_gap(src_calm));
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #(20 * 700_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== pid_speed_and_yaw_drive.f =====
hdl/psyd_pkg.sv
hdl/pid_speed_and_yaw_drive.sv
test/tb_pid_speed_and_yaw_drive.sv
